FILE: hw/rtl/opst_pkg.sv
// Package for the odd-only sieve table: sizes, request codes, controller states
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package opst_pkg;

  // Highest index the mark store holds
  localparam int MaxLimit  = 65535;
  localparam int IdxW      = $clog2(MaxLimit + 1);
  // Candidate, square and multiple pointer run one bit past the index range
  localparam int PtrW      = IdxW + 1;
  // Width of the request and register fields on the ports
  localparam int FieldW    = 16;
  // Common width for comparing port fields against the saturated limit
  localparam int CmpW      = ((IdxW > FieldW) ? IdxW : FieldW) + 1;
  localparam int FirstOdd  = 3;
  localparam int FirstOddSq = FirstOdd * FirstOdd;
  localparam int SieveLimitReset = 65535;

  typedef enum logic {
    OpRebuild = 1'b0,
    OpLookup  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFill,
    StOuter,
    StTest,
    StCross,
    StDone
  } state_e;

  typedef struct packed {
    logic rebuild_init;
    logic fill_step;
    logic rd_mark;
    logic load_cross;
    logic cross_step;
    logic next_outer;
    logic lookup;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic sq_over;
    logic ptr_over;
    logic mark;
  } dp_status_t;

endpackage

FILE: hw/rtl/opst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opst_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/opst_ctrl.sv
// Controller of the sieve table: sequences clearing pass, fill, outer scan
// and crossing-out. Depends on opst_pkg.
module opst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                op_i,
  input  opst_pkg::dp_status_t status_i,
  output opst_pkg::dp_cmd_t    cmd_o,
  output logic                busy
);
  import opst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      StClear: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          if (op_i == OpLookup) begin
            cmd_o.lookup = 1'b1;
          end else begin
            cmd_o.rebuild_init = 1'b1;
            state_d = StFill;
          end
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = StOuter;
        end
      end
      StOuter: begin
        // stop once the candidate square passes the limit
        if (status_i.sq_over) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_mark = 1'b1;
          state_d = StTest;
        end
      end
      StTest: begin
        if (status_i.mark) begin
          cmd_o.load_cross = 1'b1;
          state_d = StCross;
        end else begin
          cmd_o.next_outer = 1'b1;
          state_d = StOuter;
        end
      end
      StCross: begin
        if (status_i.ptr_over) begin
          cmd_o.next_outer = 1'b1;
          state_d = StOuter;
        end else begin
          cmd_o.cross_step = 1'b1;
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

FILE: hw/rtl/opst_dp.sv
// Datapath of the sieve table: limit register, sweep counters, mark store
// and result registers. Depends on opst_pkg and opst_ram.
module opst_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [opst_pkg::FieldW-1:0]   cfg_wdata_i,
  input  logic [opst_pkg::FieldW-1:0]   query_index_i,
  input  opst_pkg::dp_cmd_t             cmd_i,
  output opst_pkg::dp_status_t          status_o,
  output logic                          done_o,
  output logic                          prime_mark_o,
  output logic                          out_of_range_o
);
  import opst_pkg::*;

  logic [FieldW-1:0] limit_q;
  logic [IdxW-1:0]   fill_q;
  logic [PtrW-1:0]   cand_q, sq_q, ptr_q, step_q;
  logic              pend_q, oor_q;

  logic [CmpW-1:0]   cfg_ext, lim_sat, q_ext;
  logic [PtrW-1:0]   lim_p;
  logic              q_oor;
  logic              ram_we, ram_re, ram_wdata, ram_rdata;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;

  // saturate the configured limit at the store size
  assign cfg_ext = CmpW'(limit_q);
  assign lim_sat = (cfg_ext > CmpW'(MaxLimit)) ? CmpW'(MaxLimit) : cfg_ext;
  assign lim_p   = PtrW'(lim_sat);
  assign q_ext   = CmpW'(query_index_i);
  assign q_oor   = q_ext > lim_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= FieldW'(SieveLimitReset);
      fill_q  <= '0;
      cand_q  <= PtrW'(FirstOdd);
      sq_q    <= PtrW'(FirstOddSq);
      ptr_q   <= '0;
      step_q  <= '0;
      pend_q  <= 1'b0;
      oor_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.rebuild_init) begin
        fill_q <= '0;
        cand_q <= PtrW'(FirstOdd);
        sq_q   <= PtrW'(FirstOddSq);
      end
      if (cmd_i.fill_step) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.load_cross) begin
        ptr_q  <= sq_q;
        step_q <= cand_q << 1;
      end
      if (cmd_i.cross_step) begin
        ptr_q <= ptr_q + step_q;
      end
      if (cmd_i.next_outer) begin
        // (i+2)^2 = i^2 + 4i + 4
        cand_q <= cand_q + PtrW'(2);
        sq_q   <= sq_q + (cand_q << 2) + PtrW'(4);
      end
      pend_q <= cmd_i.lookup;
      oor_q  <= cmd_i.lookup & q_oor;
    end
  end

  assign ram_we    = cmd_i.fill_step | cmd_i.cross_step;
  assign ram_waddr = cmd_i.fill_step ? fill_q : ptr_q[IdxW-1:0];
  assign ram_wdata = cmd_i.fill_step;
  assign ram_re    = cmd_i.rd_mark | cmd_i.lookup;
  assign ram_raddr = cmd_i.lookup ? q_ext[IdxW-1:0] : cand_q[IdxW-1:0];

  opst_ram #(
    .Width (1),
    .Depth (MaxLimit + 1)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.fill_last = (fill_q == IdxW'(MaxLimit));
  assign status_o.sq_over   = sq_q > lim_p;
  assign status_o.ptr_over  = ptr_q > lim_p;
  assign status_o.mark      = ram_rdata;

  assign done_o         = pend_q | cmd_i.emit;
  assign prime_mark_o   = pend_q & ~oor_q & ram_rdata;
  assign out_of_range_o = pend_q & oor_q;

endmodule

FILE: hw/rtl/odd_prime_sieve_table.sv
// Top level of the odd-only sieve of Eratosthenes primality table.
// Depends on opst_pkg, opst_ctrl, opst_dp (and through it opst_ram).
//
// Usage:
//  - Request channel: a request is taken at a rising edge with start high and
//    busy low. cmd_i selects rebuild (OpRebuild) or lookup (OpLookup);
//    query_index_i is the index a lookup reads.
//  - Result channel: done_o pulses for one cycle with prime_mark_o and
//    out_of_range_o. The receiver cannot stall; results are never held.
//  - A lookup returns its result in the cycle after it is taken, and busy
//    stays low, so lookups stream at one per cycle (one read of the mark
//    RAM each).
//  - A rebuild raises busy for the whole rebuild: a fill pass over all
//    MaxLimit+1 marks (one RAM write per cycle), then per odd candidate i
//    with i*i at most the limit a check of its square and a read of its
//    mark, a test of the mark, and for a set mark the clearing of each odd
//    multiple from i*i in turn. A last check finds the next square past the limit;
//    the rebuild result (both flags 0) comes in the last busy cycle after it.
//  - sieve_limit_i is written when sieve_limit_we_i is high; write only
//    while idle. Limits above MaxLimit saturate.
//  - Reset: busy stays high for a clearing pass that sets all MaxLimit+1
//    marks; no result is given for it. The limit resets to 65535.
module odd_prime_sieve_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd_i,
  input  logic [opst_pkg::FieldW-1:0] query_index_i,
  input  logic                        sieve_limit_we_i,
  input  logic [opst_pkg::FieldW-1:0] sieve_limit_i,
  output logic                        done_o,
  output logic                        prime_mark_o,
  output logic                        out_of_range_o
);
  import opst_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequence the rebuild and gate requests
  opst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (cmd_i),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy     (busy)
  );

  // hold the marks, sweep counters and results
  opst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (sieve_limit_we_i),
    .cfg_wdata_i    (sieve_limit_i),
    .query_index_i  (query_index_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .done_o         (done_o),
    .prime_mark_o   (prime_mark_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

FILE: hw/rtl/opst_assert.sv
// Port-level checks for the sieve table, bound to the top level.
// Depends on opst_pkg and odd_prime_sieve_table.
module opst_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cmd_i,
  input logic done_o,
  input logic prime_mark_o,
  input logic out_of_range_o
);
  import opst_pkg::*;

  // a lookup request answers in the next cycle
  a_lookup_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == OpLookup) |=> done_o)
    else $error("lookup result missing");

  // a rebuild request makes the block busy
  a_rebuild_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == OpRebuild) |=> busy)
    else $error("rebuild did not raise busy");

  // the rebuild result ends the busy period
  a_rebuild_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && busy) |=> !busy)
    else $error("busy held after rebuild result");

  // flags are exclusive and quiet outside a result
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(prime_mark_o && out_of_range_o))
    else $error("mark and out-of-range both set");

  a_flags_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!prime_mark_o && !out_of_range_o))
    else $error("result flags without done");

endmodule

bind odd_prime_sieve_table opst_assert u_opst_assert (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .done_o         (done_o),
  .prime_mark_o   (prime_mark_o),
  .out_of_range_o (out_of_range_o)
);

FILE: tb/testbench.sv
// Self-checking testbench for odd_prime_sieve_table: rebuild and lookup requests
// against a software sieve, with limit changes between phases.
// Depends on opst_pkg and the odd_prime_sieve_table RTL.
`timescale 1ns / 1ps

module testbench;
  import opst_pkg::*;

  // Worst run: clearing pass, eight rebuilds at up to the largest limit and
  // ~1100 lookups with the longest random gaps, taken several times over.
  localparam int WatchdogNs  = 12_000_000;
  // Bound on the final drain: one full rebuild at the largest limit
  localparam int DrainCycles = 200_000;
  localparam int MaxPrinted  = 40;

  typedef struct packed {
    logic mark;
    logic beyond;
  } mark_answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd_i = 1'b0;
  logic [FieldW-1:0] query_index_i = '0;
  logic              sieve_limit_we_i = 1'b0;
  logic [FieldW-1:0] sieve_limit_i = '0;
  logic              done_o;
  logic              prime_mark_o;
  logic              out_of_range_o;

  // Shadow of the mark table and the limit register
  bit           prime_bits [0:MaxLimit];
  int unsigned  limit_shadow = SieveLimitReset;
  mark_answer_t awaited_answers[$];

  bit          start_held;
  bit          steady_flow;
  int unsigned errors;
  int unsigned n_lookups, n_rebuilds, n_beyond, n_prime_hits, n_settings;

  odd_prime_sieve_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .query_index_i   (query_index_i),
    .sieve_limit_we_i(sieve_limit_we_i),
    .sieve_limit_i   (sieve_limit_i),
    .done_o          (done_o),
    .prime_mark_o    (prime_mark_o),
    .out_of_range_o  (out_of_range_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The register is 16 bits wide, but keep the saturation in case the store
  // is ever built smaller than the field.
  function automatic int unsigned effective_limit();
    return (limit_shadow > MaxLimit) ? MaxLimit : limit_shadow;
  endfunction

  // Set every mark, then cross out odd multiples of each surviving odd
  // candidate from its square up to the limit.
  function automatic void rebuild_table();
    int unsigned lim, cand, mult;
    lim = effective_limit();
    foreach (prime_bits[k]) prime_bits[k] = 1'b1;
    for (cand = FirstOdd; cand * cand <= lim; cand += 2) begin
      if (prime_bits[cand]) begin
        for (mult = cand * cand; mult <= lim; mult += 2 * cand) prime_bits[mult] = 1'b0;
      end
    end
  endfunction

  function automatic mark_answer_t lookup_answer(input logic [FieldW-1:0] idx);
    mark_answer_t ans;
    if (idx > effective_limit()) begin
      ans.mark   = 1'b0;
      ans.beyond = 1'b1;
    end else begin
      ans.mark   = prime_bits[idx];
      ans.beyond = 1'b0;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    errors++;
    if (errors <= MaxPrinted)
      $display("mismatch %0d at %0t: %s expected %0d, got %0d", errors, $time, what, want,
               got);
  endtask

  // Results cannot be held off: take each one at the edge that ends its cycle.
  always @(posedge clk_i) begin : check_results
    mark_answer_t want;
    if (rst_ni && done_o) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("unexpected result, pending count", 0, 1);
      end else begin
        want = awaited_answers.pop_front();
        if (prime_mark_o !== want.mark)
          report_mismatch("prime_mark", 32'(want.mark), 32'(prime_mark_o));
        if (out_of_range_o !== want.beyond)
          report_mismatch("out_of_range", 32'(want.beyond), 32'(out_of_range_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one request, hold it until taken, predict its result, then draw
  // the gap before the next one. With no gap, leave start high so that the
  // next request follows on the very next edge.
  task automatic send_request(input op_e op, input logic [FieldW-1:0] idx);
    int unsigned gap;
    mark_answer_t ans;
    start         <= 1'b1;
    cmd_i         <= op;
    query_index_i <= idx;
    start_held     = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OpRebuild) begin
      rebuild_table();
      ans.mark   = 1'b0;
      ans.beyond = 1'b0;
      n_rebuilds++;
    end else begin
      ans = lookup_answer(idx);
      n_lookups++;
      if (ans.beyond) n_beyond++;
      if (ans.mark) n_prime_hits++;
    end
    awaited_answers.push_back(ans);
    gap = steady_flow ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start     <= 1'b0;
      start_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every result is in and busy is low.
  task automatic wait_idle();
    if (start_held) begin
      start     <= 1'b0;
      start_held = 1'b0;
    end
    do @(posedge clk_i); while (awaited_answers.size() != 0 || busy);
  endtask

  task automatic write_limit(input logic [FieldW-1:0] value);
    wait_idle();
    sieve_limit_we_i <= 1'b1;
    sieve_limit_i    <= value;
    @(posedge clk_i);
    sieve_limit_we_i <= 1'b0;
    limit_shadow      = 32'(value);
    n_settings++;
  endtask

  // Mostly odd indices of 3 or more within the limit, where the sieve means
  // something; the rest beyond the limit or anywhere at all.
  function automatic logic [FieldW-1:0] pick_index();
    int unsigned lim, r, v;
    lim = effective_limit();
    r   = $urandom_range(0, 99);
    if (r < 70 && lim >= FirstOdd) begin
      v = $urandom_range(FirstOdd, lim) | 1;
      if (v > lim) v -= 2;
    end else if (r < 85 && lim < MaxLimit) begin
      v = $urandom_range(lim + 1, MaxLimit);
    end else begin
      v = $urandom_range(0, MaxLimit);
    end
    return v[FieldW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before any rebuild every mark reads as set, even and composite alike.
  task automatic test_reset_marks();
    send_request(OpLookup, 16'd0);
    send_request(OpLookup, 16'd1);
    send_request(OpLookup, 16'd2);
    send_request(OpLookup, 16'd9);
    send_request(OpLookup, 16'hFFFF);
  endtask

  // Full-size table: smallest odd prime, squares, the largest 16-bit prime,
  // the top index (composite) and untouched even entries.
  task automatic test_full_rebuild();
    send_request(OpRebuild, 16'hFFFF);
    send_request(OpLookup, 16'd3);
    send_request(OpLookup, 16'd9);
    send_request(OpLookup, 16'd25);
    send_request(OpLookup, 16'd65521);
    send_request(OpLookup, 16'hFFFF);
    send_request(OpLookup, 16'hAAAA);
  endtask

  // Shrink the limit: old marks stay, range check follows the new limit.
  task automatic test_limit_without_rebuild();
    write_limit(16'd100);
    send_request(OpLookup, 16'd99);
    send_request(OpLookup, 16'd101);
    send_request(OpLookup, 16'hFFFF);
    send_request(OpRebuild, 16'h5555);
    send_request(OpLookup, 16'd97);
    send_request(OpLookup, 16'd91);
  endtask

  // Limit under the smallest odd square: nothing is crossed out, and raising
  // the limit alone does not cross out 9 either.
  task automatic test_tiny_limits();
    write_limit(16'd4);
    send_request(OpRebuild, 16'd0);
    send_request(OpLookup, 16'd3);
    send_request(OpLookup, 16'd4);
    send_request(OpLookup, 16'd5);
    write_limit(16'd9);
    send_request(OpLookup, 16'd9);
    send_request(OpRebuild, 16'd9);
    send_request(OpLookup, 16'd9);
    send_request(OpLookup, 16'd10);
  endtask

  // One limit setting: lookups on the stale table first, then a rebuild at a
  // random point early on, then a long stream of lookups.
  task automatic run_random_phase(input int unsigned lo, input int unsigned hi,
                                  input int unsigned count);
    int unsigned rebuild_at;
    write_limit(FieldW'($urandom_range(lo, hi)));
    rebuild_at = $urandom_range(0, 20);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) steady_flow = !steady_flow;
      if (k == rebuild_at) send_request(OpRebuild, FieldW'($urandom_range(0, MaxLimit)));
      else send_request(OpLookup, pick_index());
    end
  endtask

  initial begin : main
    int unsigned guard;
    foreach (prime_bits[k]) prime_bits[k] = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold requests until the clearing pass is over
    wait_idle();

    test_reset_marks();
    test_full_rebuild();
    test_limit_without_rebuild();
    test_tiny_limits();

    run_random_phase(9, 64, 270);
    run_random_phase(65, 1024, 270);
    run_random_phase(1025, MaxLimit, 270);
    run_random_phase(9, MaxLimit, 270);

    if (start_held) begin
      start     <= 1'b0;
      start_held = 1'b0;
    end
    guard = 0;
    while (awaited_answers.size() != 0 && guard < DrainCycles) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (awaited_answers.size() != 0)
      report_mismatch("results never delivered", 0, awaited_answers.size());

    $display("Covered %0d lookups (%0d beyond the limit, %0d on set marks) and %0d rebuilds",
             n_lookups, n_beyond, n_prime_hits, n_rebuilds);
    $display("across %0d limit writes; %0d mismatches", n_settings, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(WatchdogNs);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/opst_pkg.sv
hw/rtl/opst_ram.sv
hw/rtl/opst_ctrl.sv
hw/rtl/opst_dp.sv
hw/rtl/odd_prime_sieve_table.sv
hw/rtl/opst_assert.sv
tb/testbench.sv
